// ===== rtl/sdlc_pkg.sv =====
// Shared types and constants for the serial decimal LED color command block.
// No dependencies; the block and checker use scoped names, the testbench imports it.
package sdlc_pkg;

	// accumulator width (valid range 11..32)
	localparam int ACC_BITS = 16;
	localparam logic [ACC_BITS-1:0] ACC_MAX = '1;

	localparam int VAL_W  = 16;              // entered_value / register width
	localparam int CMP_W  = (ACC_BITS > VAL_W) ? ACC_BITS : VAL_W;
	localparam logic [15:0] IDLE_MAX = 16'hFFFF;

	// config register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HANDSHAKE = 1'd1;

	localparam logic [15:0] TIMEOUT_RST   = 16'd1000;
	localparam logic [15:0] HANDSHAKE_RST = 16'd9090;

	// item kinds
	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	localparam logic [7:0] CHAR_0 = 8'h30;
	localparam logic [7:0] CHAR_9 = 8'h39;

	// result status codes
	localparam logic [2:0] ST_HANDSHAKE = 3'd0;
	localparam logic [2:0] ST_CHANNEL   = 3'd1;
	localparam logic [2:0] ST_ALL_OFF   = 3'd2;
	localparam logic [2:0] ST_ZERO      = 3'd3;
	localparam logic [2:0] ST_NO_EFFECT = 3'd4;

	// command value that clears all channels
	localparam int CMD_CLEAR = 1024;

endpackage

// ===== rtl/sdlc_in_if.sv =====
// Input channel: one beat is a received byte or one timer tick.
// Standalone; no package dependency.
interface sdlc_in_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] rx_byte;

	modport source (output valid, output kind, output rx_byte, input ready);
	modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

// ===== rtl/sdlc_out_if.sv =====
// Result channel: status, completed number and packed pixel word per beat.
// Standalone; no package dependency.
interface sdlc_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [15:0] entered_value;
	logic [31:0] pixel_word;

	modport source (output valid, output status, output entered_value,
		output pixel_word, input ready);
	modport sink   (input valid, input status, input entered_value,
		input pixel_word, output ready);
endinterface

// ===== rtl/serial_decimal_led_color_command.sv =====
// Serial decimal LED color command block: parser, link arming and channel update.
// Depends on sdlc_pkg, sdlc_in_if and sdlc_out_if.
// An accepted beat is held in the input register; its result then goes to the result register.
// Throughput: one input beat per cycle; one input register feeds a single pass
// of parse/decode logic into one result register, both stall only on a full output.
// Reset (arst_n low, asynchronous): accumulator, idle count, link and all four
// levels clear, timeout returns to 1000 ticks and handshake code to 9090.
module serial_decimal_led_color_command (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [sdlc_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [15:0]                       cfg_wdata,
	sdlc_in_if.sink                           in_ch,
	sdlc_out_if.source                        out_ch
);

	localparam int AB = sdlc_pkg::ACC_BITS;

	// ---------------- configuration registers ----------------
	logic [15:0] timeout_q;
	logic [15:0] handshake_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q   <= sdlc_pkg::TIMEOUT_RST;
			handshake_q <= sdlc_pkg::HANDSHAKE_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				sdlc_pkg::CFG_TIMEOUT:   timeout_q   <= cfg_wdata;
				sdlc_pkg::CFG_HANDSHAKE: handshake_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// ---------------- input register (stage 1) ----------------
	// The stage advances whenever the result register is free or being drained,
	// so an item that completes a number never overwrites an untaken result.
	logic       valid_s1;
	logic       kind_s1;
	logic [7:0] byte_s1;
	logic       out_valid_q;
	logic       s1_go;
	logic       s1_fire;

	assign s1_go       = !out_valid_q || out_ch.ready;
	assign s1_fire     = valid_s1 && s1_go;
	assign in_ch.ready = !valid_s1 || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			kind_s1 <= in_ch.kind;
			byte_s1 <= in_ch.rx_byte;
		end
	end

	// ---------------- parser state ----------------
	logic [AB-1:0] acc_q;
	logic          started_q;
	logic [15:0]   idle_q;
	logic          link_q;
	logic [7:0]    red_q, green_q, blue_q, white_q;

	// digit accumulate: acc*10 + d, saturating
	logic          is_byte, is_digit;
	logic [3:0]    digit;
	logic [AB+3:0] acc_x10;
	logic [AB+3:0] acc_sum;
	logic [AB-1:0] acc_next_digit;
	logic [15:0]   idle_inc;
	logic          timed_out;
	logic          finish;

	assign is_byte  = (kind_s1 == sdlc_pkg::KIND_BYTE);
	assign is_digit = is_byte && (byte_s1 >= sdlc_pkg::CHAR_0) && (byte_s1 <= sdlc_pkg::CHAR_9);
	assign digit    = byte_s1[3:0];
	assign acc_x10  = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0};
	assign acc_sum  = acc_x10 + (AB+4)'(digit);
	assign acc_next_digit = (acc_sum > (AB+4)'(sdlc_pkg::ACC_MAX)) ?
		sdlc_pkg::ACC_MAX : acc_sum[AB-1:0];

	// idle count saturates so a maxed timeout never fires
	assign idle_inc  = (idle_q == sdlc_pkg::IDLE_MAX) ? idle_q : idle_q + 16'd1;
	assign timed_out = idle_inc > timeout_q;

	// number ends on a non-digit byte or on a tick past the timeout
	assign finish = started_q && ((is_byte && !is_digit) || (!is_byte && timed_out));

	// ---------------- command decode on the completed number ----------------
	logic                     hs_match;
	logic                     below_clear;
	logic [7:0]               lvl;
	logic [2:0]               status_d;
	logic                     result_d;
	logic                     link_d;
	logic [7:0]               red_d, green_d, blue_d, white_d;

	assign hs_match    = sdlc_pkg::CMP_W'(acc_q) == sdlc_pkg::CMP_W'(handshake_q);
	assign below_clear = (acc_q >> 10) == '0;
	assign lvl         = acc_q[7:0];

	always_comb begin
		status_d = sdlc_pkg::ST_NO_EFFECT;
		result_d = 1'b0;
		link_d   = link_q;
		red_d    = red_q;
		green_d  = green_q;
		blue_d   = blue_q;
		white_d  = white_q;
		if (finish) begin
			if (!link_q) begin
				// before handshake only the matching code counts
				if (hs_match) begin
					link_d   = 1'b1;
					result_d = 1'b1;
					status_d = sdlc_pkg::ST_HANDSHAKE;
				end
			end else begin
				result_d = 1'b1;
				if (acc_q == '0) begin
					status_d = sdlc_pkg::ST_ZERO;
				end else if (below_clear) begin
					// upper two bits pick the channel, low byte is the level
					status_d = sdlc_pkg::ST_CHANNEL;
					unique case (acc_q[9:8])
						2'd0:    red_d   = lvl;
						2'd1:    green_d = lvl;
						2'd2:    blue_d  = lvl;
						default: white_d = lvl;
					endcase
				end else if (acc_q == AB'(sdlc_pkg::CMD_CLEAR)) begin
					status_d = sdlc_pkg::ST_ALL_OFF;
					red_d    = '0;
					green_d  = '0;
					blue_d   = '0;
					white_d  = '0;
				end else begin
					status_d = sdlc_pkg::ST_NO_EFFECT;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q     <= '0;
			started_q <= 1'b0;
			idle_q    <= '0;
			link_q    <= 1'b0;
			red_q     <= '0;
			green_q   <= '0;
			blue_q    <= '0;
			white_q   <= '0;
		end else if (s1_fire) begin
			link_q  <= link_d;
			red_q   <= red_d;
			green_q <= green_d;
			blue_q  <= blue_d;
			white_q <= white_d;
			if (is_digit) begin
				acc_q     <= acc_next_digit;
				started_q <= 1'b1;
				idle_q    <= '0;
			end else if (finish) begin
				acc_q     <= '0;
				started_q <= 1'b0;
				idle_q    <= '0;
			end else if (!is_byte && started_q) begin
				idle_q <= idle_inc;
			end
		end
	end

	// ---------------- result register ----------------
	logic [2:0]  status_q;
	logic [15:0] value_q;
	logic [31:0] pixel_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go) begin
			out_valid_q <= s1_fire && result_d;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && result_d) begin
			status_q <= status_d;
			value_q  <= 16'(acc_q);
			pixel_q  <= {white_d, green_d, red_d, blue_d};
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.status        = status_q;
	assign out_ch.entered_value = value_q;
	assign out_ch.pixel_word    = pixel_q;

endmodule

// ===== rtl/sdlc_checker.sv =====
// Port-level checks for serial_decimal_led_color_command, bound to the top level.
// Depends on sdlc_pkg.
module sdlc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  status,
	input logic [15:0] entered_value,
	input logic [31:0] pixel_word
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) &&
		$stable(entered_value) && $stable(pixel_word))
		else $error("result changed while stalled");

	// a fresh result follows an accepted beat through the input and result registers
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result without matching input beat");

	// clear command reports 1024 and a dark pixel
	a_all_off: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == sdlc_pkg::ST_ALL_OFF |->
		entered_value == 16'd1024 && pixel_word == 32'd0)
		else $error("all-off result inconsistent");

	// channel set only for 1..1023
	a_channel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == sdlc_pkg::ST_CHANNEL |->
		entered_value != 16'd0 && entered_value < 16'd1024)
		else $error("channel set outside command range");

endmodule

bind serial_decimal_led_color_command sdlc_checker u_sdlc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_ch.valid),
	.in_ready      (in_ch.ready),
	.out_valid     (out_ch.valid),
	.out_ready     (out_ch.ready),
	.status        (out_ch.status),
	.entered_value (out_ch.entered_value),
	.pixel_word    (out_ch.pixel_word)
);

// ===== sim/serial_decimal_led_color_command_tb.sv =====
// Self-checking testbench for the serial decimal LED color command block.
// Depends on sdlc_pkg, sdlc_in_if, sdlc_out_if and serial_decimal_led_color_command.
// Byte/tick beats go in, predicted command results are checked in order.
module serial_decimal_led_color_command_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import sdlc_pkg::*;

	localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
	localparam int STALL_LIMIT  = 3000;  // cycles with no beat moving on either side
	localparam int DRAIN_CYCLES = 8;     // margin past the input and result registers
	localparam int TICK_END_MAX = 64;    // end numbers by timeout only for short timeouts

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] value;
		logic [31:0] pixel;
	} cmd_result_t;

	// Tracks the parser/link/color state and the queue of command results owed.
	class pixel_cmd_scoreboard;
		logic [15:0]         timeout_ticks;
		logic [15:0]         handshake_code;
		logic [ACC_BITS-1:0] acc;
		bit                  started;
		bit                  link_up;
		logic [15:0]         idle_ticks;
		logic [7:0]          red, green, blue, white;
		cmd_result_t         pending_cmd_results[$];
		int                  mismatches;
		int                  checked;
		int                  status_seen[5];

		function new();
			timeout_ticks  = TIMEOUT_RST;
			handshake_code = HANDSHAKE_RST;
			acc            = '0;
			started        = 1'b0;
			link_up        = 1'b0;
			idle_ticks     = '0;
			red            = '0;
			green          = '0;
			blue           = '0;
			white          = '0;
			mismatches     = 0;
			checked        = 0;
			foreach (status_seen[i]) status_seen[i] = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] v);
			if (idx == CFG_TIMEOUT)
				timeout_ticks = v;
			else if (idx == CFG_HANDSHAKE)
				handshake_code = v;
		endfunction

		function int outstanding();
			return pending_cmd_results.size();
		endfunction

		// A number just ended: arm the link or apply it as a color command.
		function void complete_number();
			logic [ACC_BITS-1:0] v;
			logic [2:0]          st;
			v          = acc;
			acc        = '0;
			started    = 1'b0;
			idle_ticks = '0;
			if (!link_up) begin
				if (v != handshake_code)
					return;
				link_up = 1'b1;
				st      = ST_HANDSHAKE;
			end else if (v >= 1 && v <= 255) begin
				red = 8'(v);
				st  = ST_CHANNEL;
			end else if (v >= 256 && v <= 511) begin
				green = 8'(v);
				st    = ST_CHANNEL;
			end else if (v >= 512 && v <= 767) begin
				blue = 8'(v);
				st   = ST_CHANNEL;
			end else if (v >= 768 && v <= 1023) begin
				white = 8'(v);
				st    = ST_CHANNEL;
			end else if (v == CMD_CLEAR) begin
				red   = '0;
				green = '0;
				blue  = '0;
				white = '0;
				st    = ST_ALL_OFF;
			end else if (v == 0) begin
				st = ST_ZERO;
			end else begin
				st = ST_NO_EFFECT;
			end
			pending_cmd_results.push_back('{st, 16'(v), {white, green, red, blue}});
		endfunction

		function void note_beat(logic kind, logic [7:0] b);
			longint unsigned grown;
			if (kind == KIND_BYTE) begin
				if (b >= CHAR_0 && b <= CHAR_9) begin
					grown = acc;
					grown = grown * 10 + (b - CHAR_0);
					acc = (grown > ACC_MAX) ? ACC_MAX : grown[ACC_BITS-1:0];
					started    = 1'b1;
					idle_ticks = '0;
				end else if (started) begin
					complete_number();
				end
			end else if (started) begin
				if (idle_ticks != IDLE_MAX)
					idle_ticks++;
				if (idle_ticks > timeout_ticks)
					complete_number();
			end
		endfunction

		function void check_result(cmd_result_t got);
			cmd_result_t want;
			if (pending_cmd_results.size() == 0) begin
				$display("%0t: unexpected result: status %0d value %0d pixel %08h",
					$time, got.status, got.value, got.pixel);
				mismatches++;
				return;
			end
			want = pending_cmd_results.pop_front();
			checked++;
			if (want.status < 5)
				status_seen[want.status]++;
			if (got.status !== want.status) begin
				$display("%0t: status mismatch: expected %0d, actual %0d",
					$time, want.status, got.status);
				mismatches++;
			end
			if (got.value !== want.value) begin
				$display("%0t: entered_value mismatch: expected %0d, actual %0d",
					$time, want.value, got.value);
				mismatches++;
			end
			if (got.pixel !== want.pixel) begin
				$display("%0t: pixel_word mismatch: expected %08h, actual %08h",
					$time, want.pixel, got.pixel);
				mismatches++;
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [15:0]          cfg_wdata;

	sdlc_in_if  in_bus();
	sdlc_out_if out_bus();

	serial_decimal_led_color_command uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_bus),
		.out_ch    (out_bus)
	);

	pixel_cmd_scoreboard sb = new();

	bit          src_gaps;      // sender inserts random bubbles
	bit          sink_gaps;     // receiver drops ready at random
	bit          hold_req;      // ask the receiver for one long hold-off
	int          beats_in;      // input beats accepted by the block
	int          sent_beats;    // input beats the driver has completed
	int          stall_cycles;  // consecutive cycles with nothing accepted
	logic [15:0] cur_timeout;   // timeout currently programmed, shapes the stimulus
	cmd_result_t seen;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Receiver: random backpressure, plus one long hold-off on request.
	// The hold-off length is counted here so the sender keeps pushing meanwhile.
	initial begin
		out_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_bus.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				out_bus.ready <= !(sink_gaps && $urandom_range(99) < 35);
			end
		end
	end

	// Both channels sampled at the rising edge; a beat moves when valid && ready.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_bus.valid && in_bus.ready) begin
				sb.note_beat(in_bus.kind, in_bus.rx_byte);
				beats_in++;
			end
			if (out_bus.valid && out_bus.ready) begin
				seen.status = out_bus.status;
				seen.value  = out_bus.entered_value;
				seen.pixel  = out_bus.pixel_word;
				sb.check_result(seen);
			end
			if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
	end

	// Watchdog: nothing moving for too long means the block hung or lost a result.
	initial begin
		wait (stall_cycles >= STALL_LIMIT);
		$display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
		$display("TEST FAILED");
		$finish;
	end

	// One input beat; entered and left at a falling edge, valid stays up afterwards.
	task automatic send_beat(input logic kind, input logic [7:0] b);
		while (src_gaps && $urandom_range(99) < 35) begin
			in_bus.valid <= 1'b0;
			@(negedge clk);
		end
		in_bus.valid   <= 1'b1;
		in_bus.kind    <= kind;
		in_bus.rx_byte <= b;
		do @(posedge clk); while (!in_bus.ready);
		sent_beats++;
		@(negedge clk);
	endtask

	task automatic send_byte(input logic [7:0] b);
		send_beat(KIND_BYTE, b);
	endtask

	// rx_byte is a don't-care on ticks; randomize it anyway
	task automatic send_ticks(input int n);
		repeat (n) send_beat(KIND_TICK, 8'($urandom_range(255)));
	endtask

	function automatic logic [7:0] pick_nondigit();
		logic [7:0] b;
		do b = 8'($urandom_range(255)); while (b >= CHAR_0 && b <= CHAR_9);
		return b;
	endfunction

	// Send a string byte by byte. With sprinkle set, short tick runs that stay
	// within the timeout land between digits (each digit restarts the count).
	task automatic send_text(input string s, input bit sprinkle);
		int lim;
		for (int i = 0; i < s.len(); i++) begin
			send_byte(s[i]);
			if (sprinkle && cur_timeout >= 1 && $urandom_range(99) < 12) begin
				lim = (cur_timeout < 4) ? cur_timeout : 4;
				send_ticks($urandom_range(1, lim));
			end
		end
	endtask

	// Register writes only happen with the block drained.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] v);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= v;
		sb.set_reg(idx, v);
		if (idx == CFG_TIMEOUT)
			cur_timeout = v;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Stop offering, wait for every owed result, then cover the pipeline depth
	// for items that end up producing nothing.
	task automatic drain();
		in_bus.valid <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	// Decimal text for one command: every channel range, clear, zero,
	// out-of-range values, range boundaries, leading zeros and saturating runs.
	function automatic string random_command();
		string s;
		int    n;
		case ($urandom_range(9))
			0: s = $sformatf("%0d", $urandom_range(1, 255));
			1: s = $sformatf("%0d", $urandom_range(256, 511));
			2: s = $sformatf("%0d", $urandom_range(512, 767));
			3: s = $sformatf("%0d", $urandom_range(768, 1023));
			4: s = $sformatf("%0d", CMD_CLEAR);
			5: s = "0";
			6: s = $sformatf("%0d", $urandom_range(1025, 65535));
			7: begin
				// 6..9 digits: usually pins the accumulator at its max
				n = $urandom_range(6, 9);
				s = "";
				repeat (n) s = $sformatf("%s%0d", s, $urandom_range(9));
			end
			8: begin
				case ($urandom_range(9))
					0: s = "1";
					1: s = "255";
					2: s = "256";
					3: s = "511";
					4: s = "512";
					5: s = "767";
					6: s = "768";
					7: s = "1023";
					8: s = "1025";
					default: s = "65535";
				endcase
			end
			default: begin
				s = $sformatf("%0d", $urandom_range(1100));
				repeat ($urandom_range(1, 3)) s = {"0", s};
			end
		endcase
		return s;
	endfunction

	// Mostly well-formed numbers with random content and endings; about one in
	// ten steps is noise (any byte, or a few stray ticks).
	task automatic random_traffic(input int target);
		int first;
		first = sent_beats;
		while (sent_beats - first < target) begin
			if ($urandom_range(99) < 10) begin
				if ($urandom_range(1))
					send_byte(8'($urandom_range(255)));
				else
					send_ticks($urandom_range(1, 3));
			end else begin
				send_text(random_command(), 1'b1);
				if (cur_timeout <= TICK_END_MAX && $urandom_range(99) < 30)
					send_ticks(cur_timeout + 1);
				else
					send_byte(pick_nondigit());
			end
		end
	endtask

	initial begin
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_idx        = '0;
		cfg_wdata      = '0;
		in_bus.valid   = 1'b0;
		in_bus.kind    = KIND_BYTE;
		in_bus.rx_byte = '0;
		src_gaps       = 1'b1;
		sink_gaps      = 1'b1;
		hold_req       = 1'b0;
		beats_in       = 0;
		sent_beats     = 0;
		stall_cycles   = 0;
		cur_timeout    = TIMEOUT_RST;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed, reset config: leading junk and an idle tick are ignored,
		// a wrong code is dropped, the default code brings the link up.
		send_byte("a");
		send_ticks(1);
		send_text("9091,", 1'b0);
		send_text("9090;", 1'b0);
		send_text("0,", 1'b0);           // zero -> no change
		send_text("255 ", 1'b0);         // red full
		send_text("1024\n", 1'b0);       // all off
		send_text("999999.", 1'b0);      // saturates at 65535 -> no effect
		drain();

		// Zero timeout: any tick ends a started number.
		write_reg(CFG_TIMEOUT, 16'd0);
		write_reg(CFG_HANDSHAKE, 16'd0);
		random_traffic(150);
		drain();

		// Long stretch with no bubbles on either side.
		src_gaps  = 1'b0;
		sink_gaps = 1'b0;
		write_reg(CFG_TIMEOUT, 16'd1);
		write_reg(CFG_HANDSHAKE, 16'hFFFF);
		random_traffic(200);
		drain();

		// Receiver holds off for a long while so the block backs up into the
		// input channel; the sender keeps offering throughout.
		src_gaps  = 1'b1;
		sink_gaps = 1'b1;
		write_reg(CFG_TIMEOUT, 16'($urandom_range(2, 20)));
		write_reg(CFG_HANDSHAKE, 16'($urandom_range(65535)));
		hold_req = 1'b1;
		random_traffic(250);
		drain();

		// Back to the reset values, written explicitly.
		write_reg(CFG_TIMEOUT, TIMEOUT_RST);
		write_reg(CFG_HANDSHAKE, HANDSHAKE_RST);
		random_traffic(200);
		drain();

		// Max timeout: a run of ticks leaves the number open,
		// so only a non-digit byte can end it.
		write_reg(CFG_TIMEOUT, 16'hFFFF);
		src_gaps = 1'b0;
		send_text("7", 1'b0);
		send_ticks(40);
		send_byte(",");
		src_gaps = 1'b1;
		random_traffic(60);
		drain();

		$display("Ran %0d input beats over six register settings; %0d results checked",
			beats_in, sb.checked);
		$display("(handshake %0d, channel set %0d, all off %0d, zero %0d, no effect %0d)",
			sb.status_seen[ST_HANDSHAKE], sb.status_seen[ST_CHANNEL],
			sb.status_seen[ST_ALL_OFF], sb.status_seen[ST_ZERO],
			sb.status_seen[ST_NO_EFFECT]);
		if (sb.mismatches == 0 && sb.outstanding() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
